FILE: hw/rtl/jsym_pkg.sv
// Shared types, constants and the microcode program of the Jacobi symbol core.
`timescale 1ns / 1ps
package jsym_pkg;

    // Width of both operands; the request fields stay 64 bits wide.
    localparam int OPERAND_BITS = 64;
    localparam int FIELD_BITS   = 64;
    localparam int STEP_W       = 3;

    typedef logic [OPERAND_BITS-1:0] operand_t;
    typedef logic [STEP_W-1:0]       step_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] numerator;
        logic [FIELD_BITS-1:0] modulus;
    } jsym_req_t;

    typedef struct packed {
        logic signed [1:0] symbol;
        logic              bad_modulus;
    } jsym_rsp_t;

    localparam logic signed [1:0] SYM_ZERO = 2'sb00;
    localparam logic signed [1:0] SYM_POS  = 2'sb01;
    localparam logic signed [1:0] SYM_NEG  = 2'sb11;

    // Datapath operation, performed when the step's jump is not taken.
    typedef enum logic [1:0] {
        OP_NOP,
        OP_HALVE,
        OP_SWAP,
        OP_SUB
    } dp_op_t;

    // Jump condition tested by each step.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_BAD,
        COND_A_ZERO,
        COND_A_ODD,
        COND_A_GE_M
    } jump_cond_t;

    typedef struct packed {
        logic       finish;
        jump_cond_t cond;
        step_t      jump_to;
        dp_op_t     op;
        step_t      next_step;
    } ucode_word_t;

    localparam step_t STEP_ENTRY  = 3'd0;
    localparam step_t STEP_LOOP   = 3'd1;
    localparam step_t STEP_STRIP  = 3'd2;
    localparam step_t STEP_ORDER  = 3'd3;
    localparam step_t STEP_REDUCE = 3'd4;
    localparam step_t STEP_FINISH = 3'd5;

    // Binary Jacobi program. A step either finishes, jumps (no datapath action)
    // or performs its operation and moves on to the step named by next_step.
    function automatic ucode_word_t ucode(input step_t pc);
        ucode_word_t w;
        case (pc)
            STEP_ENTRY:  w = '{1'b0, COND_BAD,    STEP_FINISH, OP_NOP,   STEP_LOOP};
            STEP_LOOP:   w = '{1'b0, COND_A_ZERO, STEP_FINISH, OP_NOP,   STEP_STRIP};
            STEP_STRIP:  w = '{1'b0, COND_A_ODD,  STEP_ORDER,  OP_HALVE, STEP_STRIP};
            STEP_ORDER:  w = '{1'b0, COND_A_GE_M, STEP_REDUCE, OP_SWAP,  STEP_REDUCE};
            STEP_REDUCE: w = '{1'b0, COND_NEVER,  STEP_LOOP,   OP_SUB,   STEP_LOOP};
            default:     w = '{1'b1, COND_NEVER,  STEP_FINISH, OP_NOP,   STEP_FINISH};
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/jacobi_symbol_64_core.sv
// Top level of the Jacobi symbol core: microcode sequencer and operand datapath.
`timescale 1ns / 1ps
//
//  Channel   | Ports             | Handshake
//  ----------+-------------------+------------------------------------------
//  request   | start, busy, req  | taken at a rising edge with start high
//            |                   | and busy low
//  result    | done, rsp         | rsp is valid for the single cycle in which
//            |                   | done is high; it cannot be held off
//
// The work per request grows with the number of zero bits stripped from the
// numerator and the number of subtractions of the binary Jacobi loop; both
// are bounded by about 2*OPERAND_BITS. The sequencer runs one microcode step
// per cycle over a single 64-bit subtractor and comparator. A bad modulus
// finishes at once: the entry step jumps straight to the finish step.
// Reset (rst_n, asynchronous, active low) clears the sequencer, busy and done.
// busy drops in the cycle done is shown, so a new request may be taken at the
// edge that ends the result cycle. The receiver never stalls the core.
//
// The algorithm: strip factors of two from a, flipping the sign when m is 3
// or 5 mod 8; if a < m swap them, flipping the sign when both are 3 mod 4;
// then subtract m from a. When a reaches zero the symbol is the sign if m is
// one and zero otherwise.
module jacobi_symbol_64_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  jsym_pkg::jsym_req_t req,
    output logic                done,
    output jsym_pkg::jsym_rsp_t rsp
);

    jsym_pkg::step_t       pc_reg, pc_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  bad_reg, bad_next;
    logic                  neg_reg, neg_next;
    jsym_pkg::operand_t    a_reg, a_next;
    jsym_pkg::operand_t    m_reg, m_next;
    jsym_pkg::jsym_rsp_t   rsp_reg, rsp_next;

    jsym_pkg::ucode_word_t cw;
    logic                  jump_taken;
    jsym_pkg::operand_t    req_a;
    jsym_pkg::operand_t    req_m;

    assign req_a = req.numerator[jsym_pkg::OPERAND_BITS-1:0];
    assign req_m = req.modulus[jsym_pkg::OPERAND_BITS-1:0];

    assign cw = jsym_pkg::ucode(pc_reg);

    // Condition evaluation for the current control word.
    always_comb
    begin
        case (cw.cond)
            jsym_pkg::COND_NEVER:  jump_taken = 1'b0;
            jsym_pkg::COND_BAD:    jump_taken = bad_reg;
            jsym_pkg::COND_A_ZERO: jump_taken = (a_reg == '0);
            jsym_pkg::COND_A_ODD:  jump_taken = a_reg[0];
            jsym_pkg::COND_A_GE_M: jump_taken = (a_reg >= m_reg);
            default:               jump_taken = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        bad_next  = bad_reg;
        neg_next  = neg_reg;
        a_next    = a_reg;
        m_next    = m_reg;
        rsp_next  = rsp_reg;

        if (busy_reg)
        begin
            if (cw.finish)
            begin
                busy_next           = 1'b0;
                done_next           = 1'b1;
                rsp_next.bad_modulus = bad_reg;
                if (bad_reg || (m_reg != jsym_pkg::operand_t'(1)))
                    rsp_next.symbol = jsym_pkg::SYM_ZERO;
                else
                    rsp_next.symbol = neg_reg ? jsym_pkg::SYM_NEG : jsym_pkg::SYM_POS;
            end
            else if (jump_taken)
            begin
                pc_next = cw.jump_to;
            end
            else
            begin
                pc_next = cw.next_step;
                case (cw.op)
                    jsym_pkg::OP_HALVE:
                    begin
                        // Second supplement: each factor of two flips the sign
                        // when m is 3 or 5 mod 8.
                        a_next   = a_reg >> 1;
                        neg_next = neg_reg ^ (m_reg[1] ^ m_reg[2]);
                    end
                    jsym_pkg::OP_SWAP:
                    begin
                        // Reciprocity: both odd operands 3 mod 4 flip the sign.
                        a_next   = m_reg;
                        m_next   = a_reg;
                        neg_next = neg_reg ^ (a_reg[1] & m_reg[1]);
                    end
                    jsym_pkg::OP_SUB:
                    begin
                        a_next = a_reg - m_reg;
                    end
                    default:
                    begin
                        a_next = a_reg;
                    end
                endcase
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            pc_next   = jsym_pkg::STEP_ENTRY;
            a_next    = req_a;
            m_next    = req_m;
            neg_next  = 1'b0;
            bad_next  = (req_m == '0) || !req_m[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= jsym_pkg::STEP_ENTRY;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bad_reg  <= 1'b0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            bad_reg  <= bad_next;
            neg_reg  <= neg_next;
        end
    end

    // Operand and result payload registers need no reset.
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        m_reg   <= m_next;
        rsp_reg <= rsp_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

FILE: hw/rtl/jsym_checker.sv
// Port-level checks of the Jacobi symbol core and their binding.
`timescale 1ns / 1ps
module jsym_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input jsym_pkg::jsym_req_t req,
    input logic                done,
    input jsym_pkg::jsym_rsp_t rsp
);

    // An accepted request keeps the core busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but core not busy");

    // busy only ends together with a result.
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // A result never appears while a request is still in work.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // A bad modulus always yields a zero symbol; -2 is never produced.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!rsp.bad_modulus || rsp.symbol == jsym_pkg::SYM_ZERO)
                 && (rsp.symbol != 2'sb10))
        else $error("symbol out of range or nonzero on bad modulus");

    // A bad modulus flag follows an even or zero modulus at the request, shown
    // once the entry and finish steps have run.
    a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !req.modulus[0] |=> ##2 done && rsp.bad_modulus)
        else $error("even modulus not flagged");

endmodule

bind jacobi_symbol_64_core jsym_checker u_jsym_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);

FILE: tb/testbench.sv
// Self-checking testbench of the Jacobi symbol core: directed table, then random requests.
`timescale 1ns / 1ps

module testbench;

    // The slowest legal request strips about 2*OPERAND_BITS zeros and runs about
    // 2*OPERAND_BITS subtractions. The watchdog allows many times the length of
    // such a request plus the longest sender gap.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1000;
    localparam int RANDOM_COUNT   = 1730;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam logic [63:0] OPERAND_MASK = ALL_ONES >> (64 - jsym_pkg::OPERAND_BITS);

    localparam jsym_pkg::jsym_rsp_t ANS_BAD  =
        '{symbol: jsym_pkg::SYM_ZERO, bad_modulus: 1'b1};
    localparam jsym_pkg::jsym_rsp_t ANS_ZERO =
        '{symbol: jsym_pkg::SYM_ZERO, bad_modulus: 1'b0};
    localparam jsym_pkg::jsym_rsp_t ANS_POS  =
        '{symbol: jsym_pkg::SYM_POS,  bad_modulus: 1'b0};
    localparam jsym_pkg::jsym_rsp_t ANS_NEG  =
        '{symbol: jsym_pkg::SYM_NEG,  bad_modulus: 1'b0};

    // A row of the directed table. Where has_answer is low the answer field is
    // ignored and the request is checked against the predictor instead.
    typedef struct packed {
        logic [63:0]         numerator;
        logic [63:0]         modulus;
        logic                has_answer;
        jsym_pkg::jsym_rsp_t answer;
    } directed_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    jsym_pkg::jsym_req_t req;
    logic                done;
    jsym_pkg::jsym_rsp_t rsp;

    // Answers of accepted requests, oldest first. The core has no way to
    // reorder, so each result must match the head of this queue.
    jsym_pkg::jsym_rsp_t pending_symbols[$];

    int fail_count     = 0;
    int requests_taken = 0;
    int results_seen   = 0;
    int neg_seen       = 0;
    int zero_seen      = 0;
    int pos_seen       = 0;
    int bad_seen       = 0;
    int idle_cycles    = 0;

    // Set per block of requests; while high the sender never pauses, so
    // requests arrive back to back in the very cycle busy drops.
    bit no_idle_phase = 1'b0;

    jacobi_symbol_64_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predicts the core's answer. The numerator is first reduced modulo the
    // modulus; each pass then strips the factors of two from the numerator,
    // flips the sign by the second supplement (odd strip count against a
    // modulus of 3 or 5 mod 8) and by reciprocity (both 3 mod 4), and swaps
    // the operands, reducing the new numerator modulo the new modulus.
    function automatic jsym_pkg::jsym_rsp_t jacobi_of(input logic [63:0] num_in,
                                                      input logic [63:0] mod_in);
        logic [63:0]         a;
        logic [63:0]         m;
        logic [63:0]         swap_tmp;
        int                  zeros;
        logic                negative;
        jsym_pkg::jsym_rsp_t r;
        a = num_in & OPERAND_MASK;
        m = mod_in & OPERAND_MASK;
        negative = 1'b0;
        if (m == 64'd0 || !m[0])
        begin
            return ANS_BAD;
        end
        a = a % m;
        while (a != 64'd0)
        begin
            zeros = 0;
            while (!a[0])
            begin
                a = a >> 1;
                zeros++;
            end
            if (((zeros % 2 == 1) && (m[1] ^ m[2])) ^ (a[1] & m[1]))
                negative = ~negative;
            swap_tmp = a;
            a = m % swap_tmp;
            m = swap_tmp;
        end
        r.bad_modulus = 1'b0;
        if (m != 64'd1)
            r.symbol = jsym_pkg::SYM_ZERO;
        else if (negative)
            r.symbol = jsym_pkg::SYM_NEG;
        else
            r.symbol = jsym_pkg::SYM_POS;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Sender gap: mostly none, otherwise a short or now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle_phase || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // Presents one request and returns at the edge that takes it. When no gap
    // is drawn, start simply stays high from the previous request, so it is
    // never lowered and raised within one time step.
    task automatic issue_request(input logic [63:0]         numerator,
                                 input logic [63:0]         modulus,
                                 input logic                has_answer,
                                 input jsym_pkg::jsym_rsp_t answer);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= '{numerator: numerator, modulus: modulus};
        // busy is read as it stood before the edge, which is what the core
        // itself saw when deciding to take the request.
        do
            @(posedge clk);
        while (busy);
        pending_symbols.push_back(has_answer ? answer : jacobi_of(numerator, modulus));
        requests_taken++;
    endtask

    // Result checker: done marks a result for exactly one cycle, and the
    // receiver cannot hold it off, so every done cycle is one result.
    always @(posedge clk)
    begin
        jsym_pkg::jsym_rsp_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_symbols.size() == 0)
            begin
                $error("result with nothing outstanding: symbol %0d bad_modulus %0b",
                       rsp.symbol, rsp.bad_modulus);
                fail_count++;
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (rsp.symbol !== want.symbol)
                begin
                    $error("symbol: expected %0d, got %0d", want.symbol, rsp.symbol);
                    fail_count++;
                end
                if (rsp.bad_modulus !== want.bad_modulus)
                begin
                    $error("bad_modulus: expected %0b, got %0b",
                           want.bad_modulus, rsp.bad_modulus);
                    fail_count++;
                end
                if (want.bad_modulus)
                    bad_seen++;
                else if (want.symbol == jsym_pkg::SYM_NEG)
                    neg_seen++;
                else if (want.symbol == jsym_pkg::SYM_POS)
                    pos_seen++;
                else
                    zero_seen++;
            end
        end
    end

    // Watchdog: any cycle that takes a request or shows a result restarts it.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles without progress", idle_cycles);
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        directed_row_t directed_rows[$];
        logic [63:0]   numerator;
        logic [63:0]   modulus;
        logic [63:0]   factor;
        logic [63:0]   width_mask;
        int            kind;

        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;

        // Expected answers are typed in only where they are plain: bad moduli,
        // a modulus or numerator of one, a numerator that reduces to zero, and tiny cases.
        directed_rows = '{
            '{64'h5,                  64'h0,                  1'b1, ANS_BAD},
            '{64'h0,                  64'h0,                  1'b1, ANS_BAD},
            '{64'h0,                  64'h2,                  1'b1, ANS_BAD},
            '{ALL_ONES,               ALL_ONES - 64'd1,       1'b1, ANS_BAD},
            '{64'h7,                  64'h1,                  1'b1, ANS_POS},
            '{64'h0,                  64'h1,                  1'b1, ANS_POS},
            '{ALL_ONES,               64'h1,                  1'b1, ANS_POS},
            '{64'h0,                  64'h3,                  1'b1, ANS_ZERO},
            '{64'h1,                  64'h3,                  1'b1, ANS_POS},
            '{64'h2,                  64'h3,                  1'b1, ANS_NEG},
            '{64'h2,                  64'h5,                  1'b1, ANS_NEG},
            '{64'h2,                  64'h7,                  1'b1, ANS_POS},
            '{64'h3,                  64'h7,                  1'b1, ANS_NEG},
            '{64'ha,                  64'h3,                  1'b1, ANS_POS},
            '{64'h6,                  64'h9,                  1'b1, ANS_ZERO},
            '{ALL_ONES,               ALL_ONES,               1'b1, ANS_ZERO},
            '{64'h0,                  ALL_ONES,               1'b1, ANS_ZERO},
            '{64'h1,                  ALL_ONES,               1'b1, ANS_POS},
            '{64'h1,                  64'h8000_0000_0000_0001, 1'b1, ANS_POS},
            '{ALL_ONES - 64'd1,       ALL_ONES,               1'b0, ANS_ZERO},
            '{64'h8000_0000_0000_0000, ALL_ONES,              1'b0, ANS_ZERO},
            '{ALL_ONES,               64'h8000_0000_0000_0001, 1'b0, ANS_ZERO},
            '{64'h2,                  64'hffff_ffff_ffff_ffc5, 1'b0, ANS_ZERO},
            '{64'h3,                  64'h1fff_ffff_ffff_ffff, 1'b0, ANS_ZERO},
            '{64'h1234_5678_9abc_def0, 64'hfedc_ba98_7654_3211, 1'b0, ANS_ZERO}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_request(directed_rows[i].numerator, directed_rows[i].modulus,
                          directed_rows[i].has_answer, directed_rows[i].answer);

        // Random part. Full 64-bit operands are the slow ones, so about a third of
        // the requests use narrow operands or tiny moduli to keep the run short.
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n % 64 == 0)
                no_idle_phase = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                numerator = rand64();
                modulus   = rand64() | 64'd1;
            end
            else if (kind < 60)
            begin
                // Narrow operands; the numerator is sometimes left wide so that
                // the first reduction does real work.
                width_mask = (64'd1 << $urandom_range(2, 24)) - 64'd1;
                numerator  = ($urandom_range(0, 3) == 0) ? rand64() : rand64() & width_mask;
                modulus    = (rand64() & width_mask) | 64'd1;
            end
            else if (kind < 70)
            begin
                numerator = rand64();
                modulus   = ($urandom_range(0, 7) == 0) ? 64'd0 : rand64() & ~64'd1;
            end
            else if (kind < 78)
            begin
                // Tiny odd moduli, one among them.
                numerator = rand64();
                modulus   = 64'($urandom_range(0, 15)) * 64'd2 + 64'd1;
            end
            else if (kind < 88)
            begin
                // A shared odd factor, so the answer is always zero.
                factor    = 64'($urandom_range(1, 1000)) * 64'd2 + 64'd1;
                modulus   = factor * (64'($urandom_range(0, 1 << 20)) * 64'd2 + 64'd1);
                numerator = factor * 64'($urandom);
            end
            else
            begin
                // Long runs of trailing zeros in the numerator.
                numerator = (rand64() | 64'd1) << $urandom_range(1, 63);
                modulus   = rand64() | 64'd1;
            end
            issue_request(numerator, modulus, 1'b0, ANS_ZERO);
        end

        start <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        // Nothing is outstanding; any further done would be a stray result.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests and %0d results", requests_taken, results_seen);
        $display("answers: %0d negative, %0d zero, %0d positive, %0d bad modulus",
                 neg_seen, zero_seen, pos_seen, bad_seen);
        if (fail_count == 0 && pending_symbols.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
